// ===== design/ppcc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the packet port classifier and counter.
// No dependencies; used by ppcc_parser and packet_port_classifier_counter.

package ppcc_pkg;

  // Counter width default and fixed result-field width
  localparam int unsigned COUNT_WIDTH_DEF = 64;
  localparam int unsigned TOTAL_W         = 64;

  // Frame byte position counter
  localparam int unsigned POS_W    = 7;
  localparam logic [6:0]  POS_MAX  = 7'd127;

  // Fixed byte positions of captured header fields
  localparam logic [6:0] POS_KIND_HI  = 7'd12;
  localparam logic [6:0] POS_KIND_LO  = 7'd13;
  localparam logic [6:0] POS_IHL      = 7'd14;
  localparam logic [6:0] POS_V6_NEXT  = 7'd20;
  localparam logic [6:0] POS_V4_PROTO = 7'd23;

  // Lengths and offsets, in bytes (8 bits covers lengths up to 128)
  localparam logic [7:0] ETH_HDR_LEN = 8'd14;
  localparam logic [7:0] V4_MIN_LEN  = 8'd34;
  localparam logic [7:0] V6_L4_OFF   = 8'd54;
  localparam logic [7:0] TCP_HDR_LEN = 8'd20;
  localparam logic [7:0] UDP_HDR_LEN = 8'd8;
  localparam logic [3:0] IHL_MIN     = 4'd5;

  localparam logic [15:0] KIND_IPV4 = 16'h0800;
  localparam logic [15:0] KIND_IPV6 = 16'h86DD;
  localparam logic [7:0]  PROTO_TCP = 8'd6;
  localparam logic [7:0]  PROTO_UDP = 8'd17;

  // Port register reset values
  localparam logic [15:0] HTTP_PORT_RST = 16'd80;
  localparam logic [15:0] SSH_PORT_RST  = 16'd22;
  localparam logic [15:0] DNS_PORT_RST  = 16'd53;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W     = 2;
  localparam logic [1:0]  CFG_HTTP_PORT = 2'd0;
  localparam logic [1:0]  CFG_SSH_PORT  = 2'd1;
  localparam logic [1:0]  CFG_DNS_PORT  = 2'd2;

  typedef enum logic [1:0] {
    CLASS_NONE = 2'd0,
    CLASS_HTTP = 2'd1,
    CLASS_SSH  = 2'd2,
    CLASS_DNS  = 2'd3
  } class_t;

  typedef struct packed {
    logic [15:0] http_port;
    logic [15:0] ssh_port;
    logic [15:0] dns_port;
  } port_cfg_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       end_of_frame;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         traffic_class;
    logic [TOTAL_W-1:0] http_total;
    logic [TOTAL_W-1:0] ssh_total;
    logic [TOTAL_W-1:0] dns_total;
  } out_word_t;

endpackage

// ===== design/packet_port_classifier_counter.sv =====
`timescale 1ns / 1ps
// Top level: input word register, header parser, per-class frame counters
// and result register. Depends on ppcc_pkg and ppcc_parser.
//
//  channel | ports                            | word
//  --------+----------------------------------+---------------------------------
//  input   | in_valid, in_ready, in_data      | frame byte + end-of-frame flag
//  result  | out_valid, out_ready, out_data   | class + three frame totals
//  config  | cfg_valid, cfg_ready, cfg_index, | port register write (16 bits)
//          | cfg_data                         |
//
// One byte per cycle sustained while results are taken; after its last byte is taken,
// a frame's result passes the input register, then the result register.
// Reset (synchronous, rst_n low) clears parser state and counters and loads
// the default ports 80, 22 and 53. A stalled result holds the last byte of
// the next frame in the input register; other bytes keep flowing.

module packet_port_classifier_counter #(
  parameter int unsigned COUNT_WIDTH = ppcc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  ppcc_pkg::in_word_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output ppcc_pkg::out_word_t                out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ppcc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [15:0]                        cfg_data
);

  ppcc_pkg::port_cfg_t ports_r;
  ppcc_pkg::in_word_t  in_r;
  logic                in_valid_r;
  ppcc_pkg::out_word_t out_r;
  logic                out_valid_r;
  ppcc_pkg::class_t    cls;
  logic                out_free;
  logic                advance;
  logic                emit;

  logic [COUNT_WIDTH-1:0] http_cnt_r, http_cnt_nxt;
  logic [COUNT_WIDTH-1:0] ssh_cnt_r,  ssh_cnt_nxt;
  logic [COUNT_WIDTH-1:0] dns_cnt_r,  dns_cnt_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ports_r.http_port <= ppcc_pkg::HTTP_PORT_RST;
      ports_r.ssh_port  <= ppcc_pkg::SSH_PORT_RST;
      ports_r.dns_port  <= ppcc_pkg::DNS_PORT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ppcc_pkg::CFG_HTTP_PORT: ports_r.http_port <= cfg_data;
        ppcc_pkg::CFG_SSH_PORT:  ports_r.ssh_port  <= cfg_data;
        ppcc_pkg::CFG_DNS_PORT:  ports_r.dns_port  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Non-final bytes always drain; a final byte waits for a free result slot
  assign out_free = !out_valid_r || out_ready;
  assign advance  = in_valid_r && (!in_r.end_of_frame || out_free);
  assign emit     = advance && in_r.end_of_frame;
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_r <= in_data;
    end
  end

  ppcc_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (advance),
    .frame_byte    (in_r.frame_byte),
    .end_of_frame  (in_r.end_of_frame),
    .ports         (ports_r),
    .traffic_class (cls)
  );

  always_comb begin
    http_cnt_nxt = http_cnt_r;
    ssh_cnt_nxt  = ssh_cnt_r;
    dns_cnt_nxt  = dns_cnt_r;
    unique case (cls)
      ppcc_pkg::CLASS_HTTP: http_cnt_nxt = http_cnt_r + 1'b1;
      ppcc_pkg::CLASS_SSH:  ssh_cnt_nxt  = ssh_cnt_r + 1'b1;
      ppcc_pkg::CLASS_DNS:  dns_cnt_nxt  = dns_cnt_r + 1'b1;
      ppcc_pkg::CLASS_NONE: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      http_cnt_r <= '0;
      ssh_cnt_r  <= '0;
      dns_cnt_r  <= '0;
    end else if (emit) begin
      http_cnt_r <= http_cnt_nxt;
      ssh_cnt_r  <= ssh_cnt_nxt;
      dns_cnt_r  <= dns_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r.traffic_class <= cls;
      out_r.http_total    <= ppcc_pkg::TOTAL_W'(http_cnt_nxt);
      out_r.ssh_total     <= ppcc_pkg::TOTAL_W'(ssh_cnt_nxt);
      out_r.dns_total     <= ppcc_pkg::TOTAL_W'(dns_cnt_nxt);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== design/ppcc_parser.sv =====
`timescale 1ns / 1ps
// Per-frame header parser: tracks byte position, captures ethertype, IHL,
// protocol and L4 ports, and classifies the frame on its last byte. Uses ppcc_pkg.

module ppcc_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          frame_byte,
  input  logic                end_of_frame,
  input  ppcc_pkg::port_cfg_t ports,
  output ppcc_pkg::class_t    traffic_class
);

  logic [ppcc_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [15:0] kind_r, kind_nxt;
  logic [3:0]  hw_r, hw_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [15:0] sport_r, sport_nxt;
  logic [15:0] dport_r, dport_nxt;

  // Values after this byte's capture, before the end-of-frame clear
  logic [15:0] kind_cur;
  logic [3:0]  hw_cur;
  logic [7:0]  proto_cur;
  logic [15:0] sport_cur;
  logic [15:0] dport_cur;
  logic        is_v4;
  logic        is_v6;
  logic [7:0]  pos8;
  logic [7:0]  len;
  logic [7:0]  l4_off;
  logic        hdr_ok;

  assign pos8 = {1'b0, pos_r};
  assign len  = pos8 + 8'd1;

  always_comb begin
    kind_cur = kind_r;
    if (pos_r == ppcc_pkg::POS_KIND_HI) kind_cur[15:8] = frame_byte;
    if (pos_r == ppcc_pkg::POS_KIND_LO) kind_cur[7:0]  = frame_byte;
  end

  assign is_v4 = (kind_cur == ppcc_pkg::KIND_IPV4);
  assign is_v6 = (kind_cur == ppcc_pkg::KIND_IPV6);

  always_comb begin
    hw_cur    = hw_r;
    proto_cur = proto_r;
    if (is_v4) begin
      if (pos_r == ppcc_pkg::POS_IHL)      hw_cur    = frame_byte[3:0];
      if (pos_r == ppcc_pkg::POS_V4_PROTO) proto_cur = frame_byte;
    end else if (is_v6) begin
      if (pos_r == ppcc_pkg::POS_V6_NEXT)  proto_cur = frame_byte;
    end
  end

  always_comb begin
    if (is_v4) begin
      l4_off = ppcc_pkg::ETH_HDR_LEN + {2'b00, hw_cur, 2'b00};
    end else if (is_v6) begin
      l4_off = ppcc_pkg::V6_L4_OFF;
    end else begin
      l4_off = 8'd0;
    end
  end

  // Port bytes are only taken past the ethertype
  always_comb begin
    sport_cur = sport_r;
    dport_cur = dport_r;
    if ((is_v4 || is_v6) && (pos8 > ppcc_pkg::ETH_HDR_LEN)) begin
      if (pos8 == l4_off)         sport_cur[15:8] = frame_byte;
      if (pos8 == l4_off + 8'd1)  sport_cur[7:0]  = frame_byte;
      if (pos8 == l4_off + 8'd2)  dport_cur[15:8] = frame_byte;
      if (pos8 == l4_off + 8'd3)  dport_cur[7:0]  = frame_byte;
    end
  end

  // Network header must lie inside the frame
  always_comb begin
    if (len < ppcc_pkg::ETH_HDR_LEN) begin
      hdr_ok = 1'b0;
    end else if (is_v4) begin
      hdr_ok = (len >= ppcc_pkg::V4_MIN_LEN) && (hw_cur >= ppcc_pkg::IHL_MIN) &&
               (l4_off <= len);
    end else if (is_v6) begin
      hdr_ok = (len >= ppcc_pkg::V6_L4_OFF);
    end else begin
      hdr_ok = 1'b0;
    end
  end

  // HTTP is checked before SSH
  always_comb begin
    traffic_class = ppcc_pkg::CLASS_NONE;
    if (hdr_ok) begin
      if (proto_cur == ppcc_pkg::PROTO_TCP) begin
        if (l4_off + ppcc_pkg::TCP_HDR_LEN <= len) begin
          if (sport_cur == ports.http_port || dport_cur == ports.http_port) begin
            traffic_class = ppcc_pkg::CLASS_HTTP;
          end else if (sport_cur == ports.ssh_port || dport_cur == ports.ssh_port) begin
            traffic_class = ppcc_pkg::CLASS_SSH;
          end
        end
      end else if (proto_cur == ppcc_pkg::PROTO_UDP) begin
        if ((l4_off + ppcc_pkg::UDP_HDR_LEN <= len) &&
            (sport_cur == ports.dns_port || dport_cur == ports.dns_port)) begin
          traffic_class = ppcc_pkg::CLASS_DNS;
        end
      end
    end
  end

  // Clear per-frame state after the last byte, else hold captures and advance
  always_comb begin
    if (end_of_frame) begin
      pos_nxt   = '0;
      kind_nxt  = '0;
      hw_nxt    = '0;
      proto_nxt = '0;
      sport_nxt = '0;
      dport_nxt = '0;
    end else begin
      pos_nxt   = (pos_r == ppcc_pkg::POS_MAX) ? pos_r : pos_r + 1'b1;
      kind_nxt  = kind_cur;
      hw_nxt    = hw_cur;
      proto_nxt = proto_cur;
      sport_nxt = sport_cur;
      dport_nxt = dport_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      kind_r  <= '0;
      hw_r    <= '0;
      proto_r <= '0;
      sport_r <= '0;
      dport_r <= '0;
    end else if (step) begin
      pos_r   <= pos_nxt;
      kind_r  <= kind_nxt;
      hw_r    <= hw_nxt;
      proto_r <= proto_nxt;
      sport_r <= sport_nxt;
      dport_r <= dport_nxt;
    end
  end

endmodule

// ===== tb/packet_port_classifier_counter_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for packet_port_classifier_counter: streams Ethernet frames
// byte by byte under random stalls and checks class and totals per frame.
// Depends on ppcc_pkg and the design top level.

module packet_port_classifier_counter_test;
  import ppcc_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned SHOW_LIMIT  = 10;
  localparam logic [1:0]  CFG_UNUSED  = 2'd3;
  localparam logic [15:0] KIND_ARP    = 16'h0806;
  localparam logic [7:0]  PROTO_ICMP  = 8'd1;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_word_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_word_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_HTTP_PORT;
  logic [15:0] cfg_data = '0;

  packet_port_classifier_counter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow of the parser, port registers and counters
  port_cfg_t   sh_ports = {HTTP_PORT_RST, SSH_PORT_RST, DNS_PORT_RST};
  logic [6:0]  sh_pos = '0;
  logic [15:0] sh_kind = '0;
  logic [3:0]  sh_ihl = '0;
  logic [7:0]  sh_proto = '0;
  logic [15:0] sh_sport = '0;
  logic [15:0] sh_dport = '0;
  logic [63:0] sh_http_cnt = '0;
  logic [63:0] sh_ssh_cnt = '0;
  logic [63:0] sh_dns_cnt = '0;

  in_word_t    frame_bytes_q[$];
  out_word_t   tallies_due[$];
  out_word_t   tally_want;

  int unsigned bytes_queued = 0;
  int unsigned bytes_taken = 0;
  int unsigned frames_done = 0;
  int unsigned results_seen = 0;
  int unsigned reg_writes = 0;
  int unsigned mismatches = 0;
  int unsigned class_seen[4] = '{0, 0, 0, 0};
  int unsigned in_hold = 0;
  int unsigned out_hold = 0;
  int unsigned quiet_cycles = 0;
  bit          in_steady = 1'b0;
  bit          out_steady = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int l4_start(input logic [15:0] kind, input logic [3:0] ihl);
    if (kind == KIND_IPV4) return int'(ETH_HDR_LEN) + 4 * int'(ihl);
    if (kind == KIND_IPV6) return int'(V6_L4_OFF);
    return 0;
  endfunction

  function automatic int unsigned pick_pause();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] pick_port();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 3) return sh_ports.http_port;
    if (roll < 5) return sh_ports.ssh_port;
    if (roll < 7) return sh_ports.dns_port;
    return 16'($urandom);
  endfunction

  // Advance the shadow parser by one accepted word; on the last byte of a
  // frame classify it, bump the counter and queue the result word.
  task automatic parse_and_count(input in_word_t w);
    int pos;
    int off;
    int len;
    class_t cls;
    out_word_t r;
    pos = int'(sh_pos);
    if (pos == POS_KIND_HI) sh_kind[15:8] = w.frame_byte;
    if (pos == POS_KIND_LO) sh_kind[7:0] = w.frame_byte;
    if (sh_kind == KIND_IPV4) begin
      if (pos == POS_IHL) sh_ihl = w.frame_byte[3:0];
      if (pos == POS_V4_PROTO) sh_proto = w.frame_byte;
    end else if (sh_kind == KIND_IPV6) begin
      if (pos == POS_V6_NEXT) sh_proto = w.frame_byte;
    end
    off = l4_start(sh_kind, sh_ihl);
    if (off != 0 && pos > POS_IHL) begin
      if (pos == off)     sh_sport[15:8] = w.frame_byte;
      if (pos == off + 1) sh_sport[7:0]  = w.frame_byte;
      if (pos == off + 2) sh_dport[15:8] = w.frame_byte;
      if (pos == off + 3) sh_dport[7:0]  = w.frame_byte;
    end
    if (!w.end_of_frame) begin
      if (sh_pos != POS_MAX) sh_pos++;
    end else begin
      cls = CLASS_NONE;
      len = pos + 1;
      // Every required header must lie inside the frame
      if (len >= ETH_HDR_LEN && off != 0 &&
          !(sh_kind == KIND_IPV4 && (len < V4_MIN_LEN || sh_ihl < IHL_MIN || off > len)) &&
          !(sh_kind == KIND_IPV6 && len < V6_L4_OFF)) begin
        if (sh_proto == PROTO_TCP && off + TCP_HDR_LEN <= len) begin
          if (sh_sport == sh_ports.http_port || sh_dport == sh_ports.http_port)
            cls = CLASS_HTTP;
          else if (sh_sport == sh_ports.ssh_port || sh_dport == sh_ports.ssh_port)
            cls = CLASS_SSH;
        end else if (sh_proto == PROTO_UDP && off + UDP_HDR_LEN <= len &&
                     (sh_sport == sh_ports.dns_port || sh_dport == sh_ports.dns_port)) begin
          cls = CLASS_DNS;
        end
      end
      case (cls)
        CLASS_HTTP: sh_http_cnt++;
        CLASS_SSH:  sh_ssh_cnt++;
        CLASS_DNS:  sh_dns_cnt++;
        default: ;
      endcase
      r.traffic_class = cls;
      r.http_total    = sh_http_cnt;
      r.ssh_total     = sh_ssh_cnt;
      r.dns_total     = sh_dns_cnt;
      tallies_due.push_back(r);
      class_seen[cls]++;
      frames_done++;
      sh_pos   = '0;
      sh_kind  = '0;
      sh_ihl   = '0;
      sh_proto = '0;
      sh_sport = '0;
      sh_dport = '0;
    end
  endtask

  // Build one frame of random filler with the header fields laid over it
  task automatic queue_frame(input logic [15:0] kind, input logic [3:0] ihl,
                             input logic [7:0] proto, input logic [15:0] sport,
                             input logic [15:0] dport, input int len);
    logic [7:0] body [];
    logic [31:0] ports;
    int off;
    int proto_at;
    in_word_t w;
    body = new[len];
    foreach (body[i]) body[i] = 8'($urandom);
    off = l4_start(kind, ihl);
    // other kinds: put the ports where a plain IPv4 header would hold them
    if (off == 0) off = int'(V4_MIN_LEN);
    proto_at = (kind == KIND_IPV6) ? int'(POS_V6_NEXT) : int'(POS_V4_PROTO);
    ports = {sport, dport};
    if (len > POS_KIND_HI) body[POS_KIND_HI] = kind[15:8];
    if (len > POS_KIND_LO) body[POS_KIND_LO] = kind[7:0];
    if (kind == KIND_IPV4 && len > POS_IHL) body[POS_IHL][3:0] = ihl;
    if (len > proto_at) body[proto_at] = proto;
    for (int k = 0; k < 4; k++)
      if (off + k < len) body[off + k] = ports[31 - 8 * k -: 8];
    foreach (body[i]) begin
      w.frame_byte   = body[i];
      w.end_of_frame = (i == len - 1);
      frame_bytes_q.push_back(w);
    end
    bytes_queued += len;
  endtask

  task automatic queue_random_frame();
    int unsigned roll;
    int need;
    int len;
    logic [15:0] kind;
    logic [3:0] ihl;
    logic [7:0] proto;
    roll = $urandom_range(0, 99);
    kind = (roll < 50) ? KIND_IPV4 : (roll < 85) ? KIND_IPV6 : 16'($urandom);
    ihl = ($urandom_range(0, 4) != 0) ? IHL_MIN : 4'($urandom);
    roll = $urandom_range(0, 19);
    proto = (roll < 9) ? PROTO_TCP : (roll < 18) ? PROTO_UDP : 8'($urandom);
    need = l4_start(kind, ihl);
    if (need == 0) need = int'(V4_MIN_LEN);
    need += (proto == PROTO_TCP) ? int'(TCP_HDR_LEN) : int'(UDP_HDR_LEN);
    roll = $urandom_range(0, 99);
    if (roll < 10)      len = $urandom_range(1, 24);
    else if (roll < 25) len = $urandom_range(1, need);
    else if (roll < 95) len = need + $urandom_range(0, 6);
    else                len = $urandom_range(128, 160);
    queue_frame(kind, ihl, proto, pick_port(), pick_port(), len);
  endtask

  task automatic write_port_reg(input logic [1:0] idx, input logic [15:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_HTTP_PORT: sh_ports.http_port = data;
      CFG_SSH_PORT:  sh_ports.ssh_port  = data;
      CFG_DNS_PORT:  sh_ports.dns_port  = data;
      default: ;
    endcase
    reg_writes++;
  endtask

  // Hold until every byte is taken and every result word has come back
  task automatic wait_drained();
    while (bytes_taken != bytes_queued || tallies_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_hold  <= 0;
    end else begin
      if (in_valid && in_ready) begin
        parse_and_count(in_data);
        bytes_taken++;
      end
      if (!in_valid || in_ready) begin
        if (in_hold != 0) begin
          in_hold  <= in_hold - 1;
          in_valid <= 1'b0;
        end else if (frame_bytes_q.size() != 0) begin
          in_valid <= 1'b1;
          in_data  <= frame_bytes_q.pop_front();
          in_hold  <= in_steady ? 0 : pick_pause();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_hold  <= 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (tallies_due.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOW_LIMIT)
            $display("result %0d arrived with nothing outstanding: %h", results_seen, out_data);
        end else begin
          tally_want = tallies_due.pop_front();
          if (out_data.traffic_class !== tally_want.traffic_class ||
              out_data.http_total !== tally_want.http_total ||
              out_data.ssh_total !== tally_want.ssh_total ||
              out_data.dns_total !== tally_want.dns_total) begin
            mismatches++;
            if (mismatches <= SHOW_LIMIT)
              $display("result %0d: class %0d/%0d http %0d/%0d ssh %0d/%0d dns %0d/%0d %s",
                       results_seen, tally_want.traffic_class, out_data.traffic_class,
                       tally_want.http_total, out_data.http_total,
                       tally_want.ssh_total, out_data.ssh_total,
                       tally_want.dns_total, out_data.dns_total, "(expected/actual)");
          end
        end
      end
      if (out_hold != 0) begin
        out_hold  <= out_hold - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!out_steady && $urandom_range(0, 5) == 0) out_hold <= pick_pause();
      end
    end
  end

  // Watchdog on any handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("no handshake for %0d cycles", QUIET_LIMIT);
      $display("packet_port_classifier_counter_test: FAIL");
      $finish;
    end
  end

  initial begin
    logic [15:0] shared_port;
    int unsigned phase_start;
    int unsigned phase_frames;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed frames under the reset port values
    in_steady  = ($urandom_range(0, 1) == 0);
    out_steady = ($urandom_range(0, 3) == 0);
    frame_bytes_q.push_back('{frame_byte: 8'h00, end_of_frame: 1'b1});
    frame_bytes_q.push_back('{frame_byte: 8'hFF, end_of_frame: 1'b1});
    bytes_queued += 2;
    queue_frame(KIND_IPV4, IHL_MIN, PROTO_TCP, 16'($urandom_range(1024, 65535)), 16'd80, 54);
    queue_frame(KIND_IPV4, IHL_MIN, PROTO_TCP, 16'($urandom_range(1024, 65535)), 16'd80, 53);
    queue_frame(KIND_IPV4, IHL_MIN, PROTO_TCP, 16'd22, 16'($urandom_range(1024, 65535)), 60);
    queue_frame(KIND_IPV4, IHL_MIN, PROTO_TCP, 16'd22, 16'd80, 58);
    queue_frame(KIND_IPV4, IHL_MIN, PROTO_UDP, 16'($urandom_range(1024, 65535)), 16'd53, 42);
    queue_frame(KIND_IPV4, IHL_MIN, PROTO_UDP, 16'd53, 16'($urandom_range(1024, 65535)), 41);
    queue_frame(KIND_IPV4, 4'd4, PROTO_UDP, 16'd53, 16'd53, 60);
    queue_frame(KIND_IPV4, 4'd15, PROTO_TCP, 16'd80, 16'($urandom_range(1024, 65535)), 94);
    queue_frame(KIND_IPV4, 4'd15, PROTO_UDP, 16'd53, 16'd53, 81);
    queue_frame(KIND_IPV6, IHL_MIN, PROTO_TCP, 16'($urandom_range(1024, 65535)), 16'd80, 74);
    queue_frame(KIND_IPV6, IHL_MIN, PROTO_UDP, 16'd53, 16'($urandom_range(1024, 65535)), 62);
    queue_frame(KIND_IPV6, IHL_MIN, PROTO_UDP, 16'd53, 16'd53, 53);
    queue_frame(KIND_ARP, IHL_MIN, PROTO_TCP, 16'd80, 16'd80, 60);
    queue_frame(KIND_IPV4, IHL_MIN, PROTO_ICMP, 16'd80, 16'd80, 60);
    queue_frame(KIND_IPV4, IHL_MIN, PROTO_UDP, 16'd80, 16'd22, 60);
    queue_frame(KIND_IPV4, IHL_MIN, PROTO_TCP, 16'd53, 16'd53, 60);
    queue_frame(KIND_IPV4, IHL_MIN, PROTO_TCP, 16'd80, 16'd80, 150);
    queue_frame(KIND_IPV4, IHL_MIN, PROTO_TCP, 16'd80, 16'd80, 13);
    queue_frame(KIND_IPV4, IHL_MIN, PROTO_TCP, 16'd80, 16'd80, 33);
    wait_drained();

    // Random frames across several port settings, extremes first
    for (int phase = 1; phase <= 5; phase++) begin
      case (phase)
        1: begin
          write_port_reg(CFG_HTTP_PORT, 16'h0000);
          write_port_reg(CFG_SSH_PORT, 16'hFFFF);
          write_port_reg(CFG_DNS_PORT, 16'h0000);
        end
        2: begin
          write_port_reg(CFG_HTTP_PORT, 16'hFFFF);
          write_port_reg(CFG_SSH_PORT, 16'h0000);
          write_port_reg(CFG_DNS_PORT, 16'hFFFF);
        end
        3: begin
          // same port for http and ssh: http must win
          shared_port = 16'($urandom);
          write_port_reg(CFG_HTTP_PORT, shared_port);
          write_port_reg(CFG_SSH_PORT, shared_port);
          write_port_reg(CFG_DNS_PORT, shared_port);
        end
        default: begin
          write_port_reg(CFG_HTTP_PORT, 16'($urandom));
          write_port_reg(CFG_SSH_PORT, 16'($urandom));
          write_port_reg(CFG_DNS_PORT, 16'($urandom));
        end
      endcase
      write_port_reg(CFG_UNUSED, 16'($urandom));
      in_steady  = ($urandom_range(0, 3) == 0);
      out_steady = ($urandom_range(0, 3) == 0);
      phase_start  = bytes_queued;
      phase_frames = 0;
      while (bytes_queued - phase_start < 80 || phase_frames < 2) begin
        queue_random_frame();
        phase_frames++;
      end
      wait_drained();
    end

    $display("Covered %0d frames in %0d bytes over 6 port settings: none %0d, http %0d,",
             frames_done, bytes_taken, class_seen[CLASS_NONE], class_seen[CLASS_HTTP]);
    $display("ssh %0d, dns %0d; %0d register writes, %0d mismatches, %0d results unreturned",
             class_seen[CLASS_SSH], class_seen[CLASS_DNS], reg_writes, mismatches,
             tallies_due.size());
    if (mismatches == 0 && tallies_due.size() == 0)
      $display("packet_port_classifier_counter_test: PASS");
    else
      $display("packet_port_classifier_counter_test: FAIL");
    $finish;
  end

endmodule
